// ===== rtl/cts_pkg.sv =====
// Package for the cubic trajectory sampler: field widths, register
// indexes and fixed-point constants. No dependencies.
`default_nettype none

package cts_pkg;

  localparam int unsigned AngleW = 32;
  localparam int unsigned DurW   = 20;
  localparam int unsigned CountW = 16;
  localparam int unsigned CfgIdxW = 2;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_DURATION = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SAMPLES  = 2'd1;

  localparam logic [DurW-1:0]   DUR_RESET   = 20'd1000;
  localparam logic [CountW-1:0] CNT_RESET   = 16'd2;
  localparam logic [DurW-1:0]   MIN_DUR     = 20'd100;
  localparam logic [CountW-1:0] MIN_SAMPLES = 16'd2;

  // u = 1.0 in Q1.16, and 6.0 in Q16 for the acceleration shape
  localparam logic [16:0] U_ONE   = 17'h10000;
  localparam logic [19:0] A_SIX   = 20'd393216;
  localparam logic [9:0]  MS_PER_S = 10'd1000;

  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MIN = 32'h8000_0000;

endpackage

`default_nettype wire

// ===== rtl/cts_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow
// flag and a sideband that travels with each request. No dependencies.
`default_nettype none

module cts_div #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 16,
  parameter int unsigned QW = 16,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          out_valid_o,
  output logic [QW-1:0] quo_o,
  output logic          ovf_o,
  output logic [SW-1:0] side_o
);

  localparam int unsigned HW = NW - QW;
  localparam int unsigned CW = (HW > DW) ? HW : DW;

  logic [QW:0]   vld_q;
  logic [DW-1:0] rem_q  [QW+1];
  logic [QW-1:0] bits_q [QW+1];
  logic [DW-1:0] den_q  [QW];
  logic          ovf_q  [QW+1];
  logic [SW-1:0] side_q [QW+1];

  logic [HW-1:0] hi;
  logic          ovf0;

  assign hi   = num_i[NW-1:QW];
  // quotient does not fit in QW bits
  assign ovf0 = CW'(hi) >= CW'(den_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QW-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= DW'(hi);
    bits_q[0] <= num_i[QW-1:0];
    den_q[0]  <= den_i;
    ovf_q[0]  <= ovf0;
    side_q[0] <= side_i;
  end

  for (genvar s = 1; s <= QW; s++) begin : g_stage
    logic [DW:0] rs;
    logic [DW:0] df;
    logic        ge;

    assign rs = {rem_q[s-1], bits_q[s-1][QW-1]};
    assign df = rs - {1'b0, den_q[s-1]};
    assign ge = rs >= {1'b0, den_q[s-1]};

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= ge ? df[DW-1:0] : rs[DW-1:0];
      bits_q[s] <= {bits_q[s-1][QW-2:0], ge};
      ovf_q[s]  <= ovf_q[s-1];
      side_q[s] <= side_q[s-1];
    end

    if (s < QW) begin : g_den
      always_ff @(posedge clk_i) begin
        den_q[s] <= den_q[s-1];
      end
    end
  end

  assign out_valid_o = vld_q[QW];
  assign quo_o       = bits_q[QW];
  assign ovf_o       = ovf_q[QW];
  assign side_o      = side_q[QW];

endmodule

`default_nettype wire

// ===== rtl/cubic_trajectory_sampler.sv =====
// Cubic trajectory sampler top level: input stage, smoothstep polynomial
// stages and the divider chain. Depends on cts_pkg and cts_div.
`default_nettype none

// One joint sample per request. A request is taken on every clock edge with
// start high; busy stays low, so a new request may enter in every cycle. Each
// request yields exactly one result, shown on the result ports for a single
// cycle with done_o high. A request passes through a chain of bit-per-stage
// dividers and registers: input register (1), the normalized time u divider
// (16 quotient stages plus entry, 17), polynomial stages (5), duration
// scaling of the acceleration (55 quotient stages plus entry, 56), the
// scale-by-1000 stage (1), velocity and acceleration scaling in parallel
// (32 quotient stages plus entry, 33) and the output register (1). The
// receiver cannot stall; results appear in request order. Write
// configuration only while no request is in flight; the pipeline reads the
// live registers.
module cubic_trajectory_sampler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [cts_pkg::AngleW-1:0] start_angle_i,
  input  logic signed [cts_pkg::AngleW-1:0] target_angle_i,
  input  logic                            start_present_i,
  input  logic                            target_present_i,
  input  logic [cts_pkg::CountW-1:0]      sample_index_i,
  input  logic                            cfg_we_i,
  input  logic [cts_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [cts_pkg::DurW-1:0]        cfg_wdata_i,
  output logic                            done_o,
  output logic [cts_pkg::DurW-1:0]        time_ms_o,
  output logic signed [cts_pkg::AngleW-1:0] position_o,
  output logic signed [cts_pkg::AngleW-1:0] velocity_o,
  output logic signed [cts_pkg::AngleW-1:0] acceleration_o,
  output logic                            saturated_o
);
  import cts_pkg::*;

  localparam int unsigned UQ  = 16;
  localparam int unsigned A1Q = 55;
  localparam int unsigned VQ  = 32;
  localparam int unsigned LAT = 1 + (UQ + 1) + 5 + (A1Q + 1) + 1 + (VQ + 1) + 1;

  // ---------------------------------------------------------------------
  // Configuration registers, clamped to their minimum values
  // ---------------------------------------------------------------------
  logic [DurW-1:0]   dur_q;
  logic [CountW-1:0] tot_q;
  logic [DurW-1:0]   dur_eff;
  logic [CountW-1:0] last_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q <= DUR_RESET;
      tot_q <= CNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DURATION: dur_q <= cfg_wdata_i;
        CFG_SAMPLES:  tot_q <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign dur_eff  = (dur_q < MIN_DUR) ? MIN_DUR : dur_q;
  // index of the last sample, at least one
  assign last_idx = ((tot_q < MIN_SAMPLES) ? MIN_SAMPLES : tot_q) - 16'd1;

  assign busy = 1'b0;

  // ---------------------------------------------------------------------
  // Input stage: resolve missing angles, form |delta| and its sign
  // ---------------------------------------------------------------------
  logic               in_vld_q;
  logic signed [31:0] st_q;
  logic [31:0]        dmag_q;
  logic               dneg_q;
  logic [15:0]        idx_q;

  logic signed [31:0] st_eff;
  logic signed [31:0] tg_eff;
  logic signed [32:0] delta;
  logic [32:0]        dabs;

  assign st_eff = start_present_i  ? start_angle_i  : 32'sd0;
  assign tg_eff = target_present_i ? target_angle_i : st_eff;
  assign delta  = 33'(tg_eff) - 33'(st_eff);
  assign dabs   = delta[32] ? 33'(-delta) : 33'(delta);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q   <= st_eff;
    dmag_q <= dabs[31:0];
    dneg_q <= delta[32];
    idx_q  <= sample_index_i;
  end

  // ---------------------------------------------------------------------
  // u = idx * 65536 / last_idx; quotient overflow means idx >= last_idx
  // ---------------------------------------------------------------------
  logic        u_vld;
  logic [15:0] u_quo;
  logic        u_ovf;
  logic [64:0] u_side;

  cts_div #(.NW(32), .DW(16), .QW(UQ), .SW(65)) u_div_u (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_vld_q),
    .num_i       ({idx_q, 16'd0}),
    .den_i       (last_idx),
    .side_i      ({st_q, dmag_q, dneg_q}),
    .out_valid_o (u_vld),
    .quo_o       (u_quo),
    .ovf_o       (u_ovf),
    .side_o      (u_side)
  );

  logic [16:0] u_val;
  assign u_val = u_ovf ? U_ONE : {1'b0, u_quo};

  // ---------------------------------------------------------------------
  // P1: u^2 and sample time
  // ---------------------------------------------------------------------
  logic        p1_vld_q;
  logic [16:0] p1_u_q;
  logic [33:0] p1_u2_q;
  logic [19:0] p1_tms_q;
  logic [64:0] p1_side_q;
  logic [36:0] tms_prod;

  assign tms_prod = 37'(u_val) * 37'(dur_eff);

  always_ff @(posedge clk_i) begin
    p1_u_q    <= u_val;
    p1_u2_q   <= 34'(u_val) * 34'(u_val);
    p1_tms_q  <= tms_prod[35:16];
    p1_side_q <= u_side;
  end

  // ---------------------------------------------------------------------
  // P2: u^3, velocity shape and acceleration shape
  // ---------------------------------------------------------------------
  logic        p2_vld_q;
  logic [33:0] p2_u2_q;
  logic [50:0] p2_u3_q;
  logic [16:0] p2_v16_q;
  logic [18:0] p2_amag_q;
  logic        p2_aneg_q;
  logic [19:0] p2_tms_q;
  logic [64:0] p2_side_q;

  logic [36:0] v_lin;
  logic [36:0] v_sq;
  logic [36:0] v_diff;
  logic [19:0] a_u12;
  logic        a_neg;

  assign v_lin  = 37'({p1_u_q, 16'd0}) * 37'd6;
  assign v_sq   = 37'(p1_u2_q) * 37'd6;
  assign v_diff = v_lin - v_sq;
  assign a_u12  = 20'(p1_u_q) * 20'd12;
  assign a_neg  = a_u12 > A_SIX;

  always_ff @(posedge clk_i) begin
    p2_u2_q   <= p1_u2_q;
    p2_u3_q   <= 51'(p1_u2_q) * 51'(p1_u_q);
    p2_v16_q  <= v_diff[32:16];
    p2_amag_q <= a_neg ? 19'(a_u12 - A_SIX) : 19'(A_SIX - a_u12);
    p2_aneg_q <= a_neg;
    p2_tms_q  <= p1_tms_q;
    p2_side_q <= p1_side_q;
  end

  // ---------------------------------------------------------------------
  // P3: blend factor, |delta| times the two rate shapes
  // ---------------------------------------------------------------------
  logic        p3_vld_q;
  logic [16:0] p3_b16_q;
  logic [48:0] p3_dv_q;
  logic [50:0] p3_da_q;
  logic        p3_aneg_q;
  logic [19:0] p3_tms_q;
  logic [64:0] p3_side_q;

  logic [50:0] b_diff;
  logic [31:0] p2_dmag;

  assign p2_dmag = p2_side_q[32:1];
  assign b_diff  = (51'(p2_u2_q) * 51'd3 << 16) - (p2_u3_q << 1);

  always_ff @(posedge clk_i) begin
    p3_b16_q  <= b_diff[48:32];
    p3_dv_q   <= 49'(p2_dmag) * 49'(p2_v16_q);
    p3_da_q   <= 51'(p2_dmag) * 51'(p2_amag_q);
    p3_aneg_q <= p2_aneg_q;
    p3_tms_q  <= p2_tms_q;
    p3_side_q <= p2_side_q;
  end

  // ---------------------------------------------------------------------
  // P4: position offset, scale rates to per-second units
  // ---------------------------------------------------------------------
  logic        p4_vld_q;
  logic [32:0] p4_pmag_q;
  logic [58:0] p4_vn_q;
  logic [60:0] p4_an_q;
  logic        p4_aneg_q;
  logic [19:0] p4_tms_q;
  logic [64:0] p4_side_q;
  logic [48:0] p_prod;

  assign p_prod = 49'(p3_side_q[32:1]) * 49'(p3_b16_q);

  always_ff @(posedge clk_i) begin
    p4_pmag_q <= p_prod[48:16];
    p4_vn_q   <= 59'(p3_dv_q) * 59'(MS_PER_S);
    p4_an_q   <= 61'(p3_da_q) * 61'(MS_PER_S);
    p4_aneg_q <= p3_aneg_q;
    p4_tms_q  <= p3_tms_q;
    p4_side_q <= p3_side_q;
  end

  // ---------------------------------------------------------------------
  // P5: position = start +- offset, 34-bit before clipping
  // ---------------------------------------------------------------------
  logic               p5_vld_q;
  logic signed [33:0] p5_pos_q;
  logic [58:0]        p5_vn_q;
  logic [60:0]        p5_an_q;
  logic               p5_aneg_q;
  logic               p5_dneg_q;
  logic [19:0]        p5_tms_q;

  logic signed [33:0] p4_start;
  logic signed [33:0] p4_off;
  logic               p4_dneg;

  assign p4_dneg  = p4_side_q[0];
  assign p4_start = 34'(signed'(p4_side_q[64:33]));
  assign p4_off   = signed'({1'b0, p4_pmag_q});

  always_ff @(posedge clk_i) begin
    p5_pos_q  <= p4_dneg ? (p4_start - p4_off) : (p4_start + p4_off);
    p5_vn_q   <= p4_vn_q;
    p5_an_q   <= p4_an_q;
    p5_aneg_q <= p4_aneg_q;
    p5_dneg_q <= p4_dneg;
    p5_tms_q  <= p4_tms_q;
  end

  // Valid bits of the polynomial stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
      p4_vld_q <= 1'b0;
      p5_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= u_vld;
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
      p4_vld_q <= p3_vld_q;
      p5_vld_q <= p4_vld_q;
    end
  end

  // ---------------------------------------------------------------------
  // First acceleration division: t = |delta|*|a16|*1000 / D
  // ---------------------------------------------------------------------
  logic          a1_vld;
  logic [A1Q-1:0] a1_quo;
  logic          a1_ovf;
  logic [114:0]  a1_side;

  cts_div #(.NW(61), .DW(DurW), .QW(A1Q), .SW(115)) u_div_a1 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (p5_vld_q),
    .num_i       (p5_an_q),
    .den_i       (dur_eff),
    .side_i      ({p5_vn_q, p5_pos_q, p5_tms_q, p5_dneg_q, p5_aneg_q}),
    .out_valid_o (a1_vld),
    .quo_o       (a1_quo),
    .ovf_o       (a1_ovf),
    .side_o      (a1_side)
  );

  // ---------------------------------------------------------------------
  // M stage: scale t by 1000 once more
  // ---------------------------------------------------------------------
  logic        m_vld_q;
  logic [64:0] m_tk_q;
  logic [114:0] m_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= a1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    m_tk_q   <= 65'(a1_quo) * 65'(MS_PER_S);
    m_side_q <= a1_side;
  end

  logic [35:0] den_t;
  assign den_t = {dur_eff, 16'd0};

  // ---------------------------------------------------------------------
  // Final divisions by D * 65536, velocity and acceleration side by side
  // ---------------------------------------------------------------------
  logic          v_vld;
  logic [VQ-1:0] v_quo;
  logic          v_ovf;
  logic [1:0]    v_side;

  cts_div #(.NW(59), .DW(36), .QW(VQ), .SW(2)) u_div_v (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (m_vld_q),
    .num_i       (m_side_q[114:56]),
    .den_i       (den_t),
    .side_i      (m_side_q[1:0]),
    .out_valid_o (v_vld),
    .quo_o       (v_quo),
    .ovf_o       (v_ovf),
    .side_o      (v_side)
  );

  logic          a2_vld;
  logic [VQ-1:0] a2_quo;
  logic          a2_ovf;
  logic [53:0]   a2_side;

  cts_div #(.NW(65), .DW(36), .QW(VQ), .SW(54)) u_div_a2 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (m_vld_q),
    .num_i       (m_tk_q),
    .den_i       (den_t),
    .side_i      (m_side_q[55:2]),
    .out_valid_o (a2_vld),
    .quo_o       (a2_quo),
    .ovf_o       (a2_ovf),
    .side_o      (a2_side)
  );

  // ---------------------------------------------------------------------
  // Output stage: apply signs, clip to 32 bits, raise the flag
  // ---------------------------------------------------------------------
  logic signed [33:0] f_pos;
  logic               pos_clip;
  logic               v_neg;
  logic               v_clip;
  logic               a_neg_f;
  logic               a_clip;
  logic [31:0]        pos_val;
  logic [31:0]        vel_val;
  logic [31:0]        acc_val;

  assign f_pos    = signed'(a2_side[53:20]);
  assign pos_clip = (f_pos[33:31] != 3'b000) && (f_pos[33:31] != 3'b111);
  assign pos_val  = !pos_clip ? f_pos[31:0] : (f_pos[33] ? NEG_MIN : POS_MAX);

  assign v_neg   = v_side[1];
  assign v_clip  = v_ovf || (v_neg ? (v_quo > NEG_MIN) : v_quo[31]);
  assign vel_val = v_clip ? (v_neg ? NEG_MIN : POS_MAX) : (v_neg ? (-v_quo) : v_quo);

  assign a_neg_f = v_side[1] ^ v_side[0];
  assign a_clip  = a2_ovf || (a_neg_f ? (a2_quo > NEG_MIN) : a2_quo[31]);
  assign acc_val = a_clip ? (a_neg_f ? NEG_MIN : POS_MAX)
                          : (a_neg_f ? (-a2_quo) : a2_quo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= a2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    time_ms_o      <= a2_side[19:0];
    position_o     <= signed'(pos_val);
    velocity_o     <= signed'(vel_val);
    acceleration_o <= signed'(acc_val);
    saturated_o    <= pos_clip || v_clip || a_clip;
  end

`ifndef SYNTH
  // every result traces back to an earlier accepted request
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT))
    else $error("result without matching request");

  // the two final dividers run in lock step
  a_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_vld == a2_vld)
    else $error("velocity and acceleration dividers out of step");

  // the first acceleration quotient always fits
  a_a1_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a1_vld |-> !a1_ovf)
    else $error("acceleration quotient overflow");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_cubic_trajectory_sampler.sv =====
// Self-checking testbench for cubic_trajectory_sampler: directed and random
// requests, a scoreboard class that predicts each joint sample and checks it.
// Depends on cts_pkg and the RTL of the sampler.
`default_nettype none

module tb_cubic_trajectory_sampler;
  import cts_pkg::*;

  typedef struct packed {
    logic [DurW-1:0]   time_ms;
    logic [AngleW-1:0] position;
    logic [AngleW-1:0] velocity;
    logic [AngleW-1:0] acceleration;
    logic              saturated;
  } sample_t;

  // Sample predictor and store of pending samples.
  class sample_scoreboard;
    longint unsigned duration;
    longint unsigned count;
    sample_t pending[$];
    int errors;

    function new();
      duration = DUR_RESET;
      count    = CNT_RESET;
      errors   = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [DurW-1:0] val);
      if (idx == CFG_DURATION) duration = val;
      else if (idx == CFG_SAMPLES) count = val[CountW-1:0];
    endfunction

    function logic [31:0] clip(longint v, inout bit sat);
      if (v > 64'sh7FFF_FFFF) begin
        v = 64'sh7FFF_FFFF;
        sat = 1;
      end
      if (v < -64'sh8000_0000) begin
        v = -64'sh8000_0000;
        sat = 1;
      end
      return v[31:0];
    endfunction

    function longint apply_sign(bit neg, longint unsigned mag);
      if (mag > 64'h1_0000_0000) mag = 64'h1_0000_0000;
      return neg ? -longint'(mag) : longint'(mag);
    endfunction

    // Predict the sample for one accepted request.
    function void note_request(logic signed [31:0] sa, logic signed [31:0] ta,
                               logic sp, logic tp, logic [15:0] idx);
      longint unsigned d, m, u, u2, u3, b16, v16, amag, dmag, pmag, vmag, t, accm;
      longint s, tg, delta, a16;
      bit dneg, aneg, sat;
      sample_t e;
      d = (duration < 100) ? 100 : duration;
      m = ((count < 2) ? 2 : count) - 1;
      u = (idx >= m) ? 65536 : (longint'(idx) * 65536) / m;
      s = sp ? longint'(sa) : 0;
      tg = tp ? longint'(ta) : s;
      delta = tg - s;
      dneg = delta < 0;
      dmag = dneg ? -delta : delta;
      sat = 0;
      u2 = u * u;
      u3 = u2 * u;
      b16 = (3 * u2 * 65536 - 2 * u3) >> 32;
      v16 = (6 * u * 65536 - 6 * u2) >> 16;
      a16 = 393216 - 12 * longint'(u);
      aneg = a16 < 0;
      amag = aneg ? -a16 : a16;
      pmag = (dmag * b16) >> 16;
      vmag = (dmag * v16 * 1000) / (d * 65536);
      t = (dmag * amag * 1000) / d;
      // a product that would not fit clips at the top
      if (t > 64'hFFFF_FFFF_FFFF_FFFF / 1000) accm = 64'h1_0000_0000;
      else accm = (t * 1000) / (d * 65536);
      e.time_ms = 20'((u * d) >> 16);
      e.position = clip(s + (dneg ? -longint'(pmag) : longint'(pmag)), sat);
      e.velocity = clip(apply_sign(dneg, vmag), sat);
      e.acceleration = clip(apply_sign(dneg != aneg, accm), sat);
      e.saturated = sat;
      pending = {pending, e};
    endfunction

    function void check_result(sample_t got);
      sample_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected sample time=%0d pos=%h", $time, got.time_ms,
                 got.position);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        $display("%0t: mismatch exp t=%0d p=%h v=%h a=%h s=%b got t=%0d p=%h v=%h a=%h s=%b",
                 $time, e.time_ms, e.position, e.velocity, e.acceleration,
                 e.saturated, got.time_ms, got.position, got.velocity,
                 got.acceleration, got.saturated);
      end
    endfunction
  endclass

  logic clk_i, rst_ni, start, busy;
  logic signed [AngleW-1:0] start_angle_i, target_angle_i;
  logic start_present_i, target_present_i;
  logic [CountW-1:0] sample_index_i;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [DurW-1:0] cfg_wdata_i;
  logic done_o, saturated_o;
  logic [DurW-1:0] time_ms_o;
  logic signed [AngleW-1:0] position_o, velocity_o, acceleration_o;

  sample_scoreboard sb = new();
  int idle_pct;

  cubic_trajectory_sampler DUT (.*);

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // Watch both ports at every edge; inputs change only by nonblocking
  // assignment, so the values read here are the ones the block samples.
  always @(posedge clk_i) begin
    sample_t got;
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_wdata_i);
      if (start && !busy)
        sb.note_request(start_angle_i, target_angle_i, start_present_i,
                        target_present_i, sample_index_i);
      if (done_o) begin
        got.time_ms = time_ms_o;
        got.position = position_o;
        got.velocity = velocity_o;
        got.acceleration = acceleration_o;
        got.saturated = saturated_o;
        sb.check_result(got);
      end
    end
  end

  // Issue one request, idling the sender for random cycles in front, and
  // hold it until taken.
  task automatic send(logic [31:0] sa, logic [31:0] ta, logic sp, logic tp,
                      logic [15:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk_i);
    end
    start <= 1;
    start_angle_i <= sa;
    target_angle_i <= ta;
    start_present_i <= sp;
    target_present_i <= tp;
    sample_index_i <= idx;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Stop issuing and wait until every pending sample has come back.
  task automatic drain();
    start <= 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DurW-1:0] val);
    drain();
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  // Random request: mostly real moves with indexes around the sample range,
  // sometimes extremes, missing endpoints or indexes far past the end.
  task automatic send_random();
    logic [31:0] sa, ta;
    logic [15:0] idx;
    int unsigned m;
    sa = $urandom;
    ta = $urandom;
    case ($urandom_range(5))
      0: sa = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: ta = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: ta = sa + $urandom_range(2000000) - 1000000;
      default: ;
    endcase
    m = (sb.count < 2) ? 1 : 32'(sb.count - 1);
    if ($urandom_range(9) < 2) idx = 16'($urandom);
    else idx = 16'($urandom_range(0, (m + 2 > 65535) ? 65535 : m + 2));
    send(sa, ta, $urandom_range(9) != 0, $urandom_range(9) != 0, idx);
  endtask

  initial begin
    rst_ni = 0;
    start = 0;
    start_angle_i = 0;
    target_angle_i = 0;
    start_present_i = 0;
    target_present_i = 0;
    sample_index_i = 0;
    cfg_we_i = 0;
    cfg_idx_i = CFG_DURATION;
    cfg_wdata_i = 0;
    idle_pct = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: reset settings, then short duration and small count.
    send(32'h0001_0000, 32'h005A_0000, 1, 1, 0);
    send(32'h0001_0000, 32'h005A_0000, 1, 1, 1);
    write_reg(CFG_DURATION, 0);
    write_reg(CFG_SAMPLES, 0);
    send(32'h8000_0000, 32'h7FFF_FFFF, 1, 1, 0);
    send(32'h7FFF_FFFF, 32'h8000_0000, 1, 1, 16'hFFFF);
    write_reg(CFG_SAMPLES, 1);
    write_reg(CFG_DURATION, 99);
    send(32'h8000_0000, 32'h7FFF_FFFF, 1, 1, 1);
    // Writes to unused indexes must change nothing.
    write_reg(2, 20'hFFFFF);
    write_reg(3, 20'h00005);
    write_reg(CFG_DURATION, 100);
    write_reg(CFG_SAMPLES, 5);
    for (int i = 0; i <= 6; i++)
      send(32'h8000_0000, 32'h7FFF_FFFF, 1, 1, 16'(i));
    send(32'h1234_5678, 32'h7FFF_FFFF, 0, 1, 2);
    send(32'h1234_5678, 32'h0000_0000, 1, 0, 2);
    send(32'hFFFF_FFFF, 32'h8000_0000, 0, 0, 1);
    write_reg(CFG_DURATION, 20'hFFFFF);
    write_reg(CFG_SAMPLES, 20'h0FFFF);
    send(32'h8000_0000, 32'h7FFF_FFFF, 1, 1, 16'h7FFF);
    send(32'h7FFF_FFFF, 32'h8000_0000, 1, 1, 16'hFFFE);
    send(32'h0000_0000, 32'hFFFF_FFFF, 1, 1, 16'hFFFF);

    // Random phases: sender idles often, then more often, then never.
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 34 : (ph == 1) ? 68 : 0;
      for (int blk = 0; blk < 5; blk++) begin
        write_reg(CFG_DURATION, 20'($urandom_range(3) == 0 ? $urandom_range(150)
                                                            : $urandom_range(20'hFFFFF)));
        write_reg(CFG_SAMPLES, 20'($urandom_range(2) == 0 ? $urandom_range(6)
                                                          : $urandom_range(16'hFFFF)));
        for (int k = 0; k < 100; k++) begin
          send_random();
          // let the pipeline run empty once mid-phase
          if (ph == 1 && blk == 2 && k == 50) drain();
        end
      end
    end

    drain();
    repeat (120) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== cubic_trajectory_sampler.f =====
rtl/cts_pkg.sv
rtl/cts_div.sv
rtl/cubic_trajectory_sampler.sv
tb/tb_cubic_trajectory_sampler.sv
